@@ src/nfa_string_recognizer_top_macros.svh @@
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef NFA_STRING_RECOGNIZER_TOP_MACROS_SVH
`define NFA_STRING_RECOGNIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define NSR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nsr assertion failed");

`define NSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nsr assertion failed");

`else

`define NSR_ASSERT_SAME(label, ante, cons)

`define NSR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/nsr_pkg.sv @@
package nsr_pkg;

  localparam int NUM_STATES_DEF  = 16;
  localparam int MAX_EDGES_DEF   = 8;
  localparam int SYMBOL_BITS_DEF = 8;

  // fixed field widths of the item
  localparam int STATE_W  = 4;
  localparam int SLOT_W   = 3;
  localparam int SYM_W    = 8;
  localparam int CNT_IN_W = 4;
  localparam int CFG_W    = 5;

  localparam logic FUNC_EDGE   = 1'b0;
  localparam logic FUNC_SYMBOL = 1'b1;

  // register select bit of paddr
  localparam int   CFG_ADDR_W      = 3;
  localparam logic REG_STATE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic edge_wr;
    logic sym_load;
    logic scan_en;
    logic finish;
  } nsr_cmd_t;

  typedef struct packed {
    logic scan_end;
  } nsr_status_t;

endpackage

@@ src/nsr_ctrl.sv @@
module nsr_ctrl
  import nsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_func,
  input  logic        out_tready,
  input  nsr_status_t status,
  output logic        in_tready,
  output logic        out_tvalid,
  output nsr_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (in_func == FUNC_SYMBOL)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_end) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.edge_wr  = in_tvalid && (in_func == FUNC_EDGE);
        cmd.sym_load = in_tvalid && (in_func == FUNC_SYMBOL);
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      ST_RESULT: begin
        cmd.finish = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ src/nsr_dp.sv @@
module nsr_dp
  import nsr_pkg::*;
#(
  parameter int NUM_STATES  = NUM_STATES_DEF,
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nsr_cmd_t            cmd,
  output nsr_status_t         status,
  input  logic [CFG_W-1:0]    state_count,
  input  logic [STATE_W-1:0]  edge_state,
  input  logic [SLOT_W-1:0]   edge_slot,
  input  logic [SYM_W-1:0]    edge_symbol,
  input  logic [STATE_W-1:0]  edge_next,
  input  logic [CNT_IN_W-1:0] edge_count,
  input  logic [SYM_W-1:0]    symbol,
  input  logic                first_symbol,
  input  logic                last_symbol,
  output logic                alive,
  output logic                final_active,
  output logic                done_res,
  output logic                accepted
);

  localparam int SW    = $clog2(NUM_STATES);
  localparam int IW    = $clog2(NUM_STATES + 1);
  localparam int LW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW    = $clog2(MAX_EDGES + 1);
  localparam int AW    = SW + LW;
  localparam int DEPTH = NUM_STATES * (2 ** LW);
  localparam int DW    = SYMBOL_BITS + STATE_W;

  logic [NUM_STATES-1:0]  active_r;
  logic [NUM_STATES-1:0]  nxt_set_r;
  logic [CW-1:0]          counts_r [NUM_STATES];
  logic [DW-1:0]          edge_mem_r [DEPTH];
  logic [DW-1:0]          rd_data_r;
  logic                   rd_vld_r;
  logic [SYMBOL_BITS-1:0] sym_r;
  logic                   last_r;
  logic [IW-1:0]          idx_r;
  logic [LW-1:0]          slot_r;

  logic [IW-1:0]          n_eff;
  logic [SW-1:0]          n_top;
  logic [SW-1:0]          cur;
  logic [CW-1:0]          cur_cnt;
  logic [CW:0]            slot_inc;
  logic                   scan_end;
  logic                   issue;
  logic                   last_slot;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic                   st_ok;
  logic                   slot_ok;
  logic [CW-1:0]          cnt_sat;
  logic [SYMBOL_BITS-1:0] rd_sym;
  logic [STATE_W-1:0]     rd_dst;
  logic                   hit;

  // effective number of states
  always_comb begin
    if (state_count == '0) begin
      n_eff = IW'(1);
    end else if (32'(state_count) > NUM_STATES) begin
      n_eff = IW'(NUM_STATES);
    end else begin
      n_eff = IW'(state_count);
    end
  end

  assign n_top = SW'(n_eff - IW'(1));

  // scan walker over states and their edge slots
  assign scan_end        = (idx_r >= n_eff);
  assign status.scan_end = scan_end;
  assign cur             = idx_r[SW-1:0];
  assign cur_cnt         = counts_r[cur];
  assign slot_inc        = {1'b0, CW'(slot_r)} + (CW + 1)'(1);
  assign last_slot       = (slot_inc >= {1'b0, cur_cnt});
  assign issue           = cmd.scan_en && !scan_end && active_r[cur] && (CW'(slot_r) < cur_cnt);
  assign rd_addr         = {cur, slot_r};

  // edge write decode
  assign st_ok   = (32'(edge_state) < NUM_STATES);
  assign slot_ok = (32'(edge_slot) < MAX_EDGES);
  assign wr_addr = {SW'(edge_state), LW'(edge_slot)};
  assign cnt_sat = (32'(edge_count) > MAX_EDGES) ? CW'(MAX_EDGES) : CW'(edge_count);

  assign rd_sym = rd_data_r[DW-1:STATE_W];
  assign rd_dst = rd_data_r[STATE_W-1:0];
  assign hit    = rd_vld_r && (rd_sym == sym_r) && (32'(rd_dst) < 32'(n_eff));

  always_ff @(posedge clk) begin
    if (cmd.edge_wr && st_ok && slot_ok) begin
      edge_mem_r[wr_addr] <= {SYMBOL_BITS'(edge_symbol), edge_next};
    end
    rd_data_r <= edge_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        counts_r[i] <= '0;
      end
    end else if (cmd.edge_wr && st_ok) begin
      counts_r[SW'(edge_state)] <= cnt_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= NUM_STATES'(1);
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
      slot_r   <= '0;
    end else begin
      rd_vld_r <= issue;
      if (cmd.sym_load) begin
        if (first_symbol) active_r <= NUM_STATES'(1);
        idx_r  <= '0;
        slot_r <= '0;
      end else if (cmd.scan_en && !scan_end) begin
        if (issue && !last_slot) begin
          slot_r <= slot_r + LW'(1);
        end else begin
          idx_r  <= idx_r + IW'(1);
          slot_r <= '0;
        end
      end
      if (cmd.finish) begin
        active_r <= last_r ? NUM_STATES'(1) : nxt_set_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sym_load) begin
      sym_r     <= SYMBOL_BITS'(symbol);
      last_r    <= last_symbol;
      nxt_set_r <= '0;
    end else if (hit) begin
      nxt_set_r[SW'(rd_dst)] <= 1'b1;
    end
    if (cmd.finish) begin
      alive        <= |nxt_set_r;
      final_active <= nxt_set_r[n_top];
      done_res     <= last_r;
      accepted     <= last_r & nxt_set_r[n_top];
    end
  end

endmodule

@@ src/nfa_string_recognizer_top.sv @@
// channel  | dir | handshake             | payload
// in       | in  | in_tvalid / in_tready   | in_tdata, in_tuser, in_tlast
// out      | out | out_tvalid / out_tready | out_tdata, out_tlast
// cfg      | in  | apb write, pready = 1   | state_count at byte address 0
//
// edge item: taken whenever the block is idle
// symbol item: the scan visits each state below the count, one slot per edge if the state
//   is active and has edges, else one step; the edge memory yields one edge per cycle
// the result waits in an output register while the next item is taken; a further result
//   stays in the result state, holding off input, until that register drains
// rst_n is synchronous: active set {state 0}, edge counts zero, state_count 1

`include "nfa_string_recognizer_top_macros.svh"

module nfa_string_recognizer_top
  import nsr_pkg::*;
#(
  parameter int NUM_STATES  = NUM_STATES_DEF,
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // edge_state, edge_slot, edge_symbol, edge_next, edge_count, symbol, zero pad
  input  logic [31:0]           in_tdata,
  // func, first_symbol
  input  logic [1:0]            in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // alive, final_active, accepted, zero pad
  output logic [7:0]            out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  nsr_cmd_t         cmd;
  nsr_status_t      status;
  logic [CFG_W-1:0] state_count_r;
  logic             cfg_wr;
  logic             alive;
  logic             final_active;
  logic             accepted;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r <= CFG_W'(1);
    end else if (cfg_wr && (cfg_paddr[2] == REG_STATE_COUNT)) begin
      state_count_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_STATE_COUNT) ? {27'd0, state_count_r} : 32'd0;

  nsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser[0]),
    .out_tready(out_tready),
    .status    (status),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .cmd       (cmd)
  );

  nsr_dp #(
    .NUM_STATES (NUM_STATES),
    .MAX_EDGES  (MAX_EDGES),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .state_count (state_count_r),
    .edge_state  (in_tdata[3:0]),
    .edge_slot   (in_tdata[6:4]),
    .edge_symbol (in_tdata[14:7]),
    .edge_next   (in_tdata[18:15]),
    .edge_count  (in_tdata[22:19]),
    .symbol      (in_tdata[30:23]),
    .first_symbol(in_tuser[1]),
    .last_symbol (in_tlast),
    .alive       (alive),
    .final_active(final_active),
    .done_res    (out_tlast),
    .accepted    (accepted)
  );

  assign out_tdata = {5'd0, accepted, final_active, alive};

  // a symbol item closes the input until its result is formed
  `NSR_ASSERT_NEXT(a_sym_blocks_input, in_tvalid && in_tready && in_tuser[0], !in_tready)
  // a formed result shows up on the output in the next cycle
  `NSR_ASSERT_NEXT(a_finish_to_out, cmd.finish, out_tvalid)
  // acceptance needs the verdict item and an active accepting state
  `NSR_ASSERT_SAME(a_accept_sane, out_tvalid && out_tdata[2], out_tlast && out_tdata[1])
  // no scan work while the block takes items
  `NSR_ASSERT_SAME(a_no_scan_idle, in_tready, !cmd.scan_en && !cmd.finish)

endmodule
